[rtl/core/yin_pkg.sv]
// ----------------------------------------------------------------------------
// yin_pkg
// Shared types and constants of the YIN pitch detector.
// ----------------------------------------------------------------------------
package yin_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int DIFF_W      = 46;
	localparam int ENERGY_W    = 42;
	localparam int NORM_W      = 18;
	localparam int CNT_W       = 14;
	localparam int CFG_W       = 30;
	localparam int QB_W        = 5;
	localparam int QUOT_W      = 20;
	localparam int LAGS_W      = 22;

	localparam logic [2:0] REG_SAMPLE_RATE   = 3'd0;
	localparam logic [2:0] REG_FRAME_LENGTH  = 3'd1;
	localparam logic [2:0] REG_THRESHOLD     = 3'd2;
	localparam logic [2:0] REG_LAG_MIN       = 3'd3;
	localparam logic [2:0] REG_LAG_MAX       = 3'd4;
	localparam logic [2:0] REG_SILENCE_LEVEL = 3'd5;

	localparam logic [DIFF_W-1:0]   DIFF_CAP   = '1;
	localparam logic [ENERGY_W-1:0] ENERGY_CAP = '1;
	localparam logic [NORM_W-1:0]   NORM_CAP   = '1;
	localparam logic [NORM_W-1:0]   NORM_ONE   = 18'd65536;

	localparam logic [QB_W-1:0] QB_NORM   = 5'd18;
	localparam logic [QB_W-1:0] QB_INTERP = 5'd20;
	localparam logic [QB_W-1:0] QB_PITCH  = 5'd16;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_sample;
	} item_t;

	typedef struct packed {
		logic [15:0] pitch_q4;
		logic [17:0] lag_q8;
		logic        silent;
		logic        below_threshold;
	} result_t;

	typedef struct packed {
		logic [17:0] sample_rate;
		logic [11:0] frame_length;
		logic [15:0] threshold_q16;
		logic [9:0]  lag_min;
		logic [10:0] lag_max;
		logic [29:0] silence_level;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sample_rate:   18'd44100,
		frame_length:  12'd2048,
		threshold_q16: 16'd6554,
		lag_min:       10'd44,
		lag_max:       11'd882,
		silence_level: 30'd0
	};

	typedef struct packed {
		logic [CNT_W-1:0]    n;
		logic [ENERGY_W-1:0] energy;
	} frame_desc_t;

	typedef struct packed {
		logic                          we;
		logic [CNT_W-1:0]              addr;
		logic signed [SAMPLE_BITS-1:0] data;
	} frame_wr_t;

endpackage

[rtl/core/yin_front.sv]
// ----------------------------------------------------------------------------
// yin_front
// Sample intake: frame store writes, sample count, saturating energy sum.
// ----------------------------------------------------------------------------
module yin_front #(
	parameter int FRAME_MAX = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  yin_pkg::item_t       item,
	input  logic [11:0]          frame_length,
	output yin_pkg::frame_wr_t   wr,
	output logic                 push,
	output yin_pkg::frame_desc_t desc
);
	import yin_pkg::*;

	localparam int FW = $clog2(FRAME_MAX + 1);

	logic [FW-1:0]            count_q, count_nx, cap;
	logic [ENERGY_W-1:0]      energy_q, energy_nx;
	logic signed [2*SAMPLE_BITS-1:0] sq;
	logic [ENERGY_W:0]        esum;
	logic                     room;

	always_comb begin
		if (frame_length == 12'd0) begin
			cap = FW'(1);
		end else if (int'(frame_length) > FRAME_MAX) begin
			cap = FW'(FRAME_MAX);
		end else begin
			cap = FW'(frame_length);
		end
		room = count_q < cap;
		sq   = item.sample * item.sample;
		esum = (ENERGY_W+1)'(energy_q) + (ENERGY_W+1)'(unsigned'(sq));
		if (room) begin
			count_nx  = count_q + FW'(1);
			energy_nx = (esum > (ENERGY_W+1)'(ENERGY_CAP)) ? ENERGY_CAP : esum[ENERGY_W-1:0];
		end else begin
			count_nx  = count_q;
			energy_nx = energy_q;
		end
	end

	assign wr.we       = accept && room;
	assign wr.addr     = CNT_W'(count_q);
	assign wr.data     = item.sample;
	assign push        = accept && item.last_sample;
	assign desc.n      = CNT_W'(count_nx);
	assign desc.energy = energy_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			energy_q <= '0;
		end else if (accept) begin
			if (item.last_sample) begin
				count_q  <= '0;
				energy_q <= '0;
			end else begin
				count_q  <= count_nx;
				energy_q <= energy_nx;
			end
		end
	end

endmodule

[rtl/core/yin_queue.sv]
// ----------------------------------------------------------------------------
// yin_queue
// Two-entry queue of closed-frame descriptors between intake and analysis.
// ----------------------------------------------------------------------------
module yin_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  yin_pkg::frame_desc_t wdata,
	input  logic                 pop,
	output yin_pkg::frame_desc_t head,
	output logic                 empty
);
	import yin_pkg::*;

	frame_desc_t entry_q [2];
	logic        rd_q, wr_q;
	logic [1:0]  cnt_q;

	assign empty = cnt_q == 2'd0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/yin_div.sv]
// ----------------------------------------------------------------------------
// yin_div
// Restoring divider, one quotient bit per cycle, saturating on overflow.
// ----------------------------------------------------------------------------
module yin_div #(
	parameter int N_W = 72,
	parameter int D_W = 56,
	parameter int Q_W = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [N_W-1:0]           dividend,
	input  logic [D_W-1:0]           divisor,
	input  logic [yin_pkg::QB_W-1:0] qbits,
	output logic                     done,
	output logic [Q_W-1:0]           quot,
	output logic                     sat
);
	import yin_pkg::*;

	localparam int DS_W = D_W + Q_W;
	localparam int CW   = (N_W > DS_W) ? N_W : DS_W;

	typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_RUN} dv_state_t;

	dv_state_t       state_q;
	logic [N_W-1:0]  rem_q;
	logic [DS_W-1:0] dsh_q;
	logic [QB_W-1:0] cnt_q;
	logic [Q_W-1:0]  quot_q;
	logic            sat_q, done_q;
	logic [CW-1:0]   rem_x, dsh_x, dif_x;
	logic            ge;

	assign rem_x = CW'(rem_q);
	assign dsh_x = CW'(dsh_q);
	assign ge    = rem_x >= dsh_x;
	assign dif_x = rem_x - dsh_x;
	assign done  = done_q;
	assign quot  = quot_q;
	assign sat   = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						rem_q   <= dividend;
						dsh_q   <= DS_W'(divisor) << qbits;
						cnt_q   <= qbits;
						quot_q  <= '0;
						sat_q   <= 1'b0;
						state_q <= DV_CHECK;
					end
				end
				DV_CHECK: begin
					if (ge) begin
						sat_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						dsh_q   <= dsh_q >> 1;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					if (ge) begin
						rem_q <= N_W'(dif_x);
					end
					quot_q <= {quot_q[Q_W-2:0], ge};
					dsh_q  <= dsh_q >> 1;
					cnt_q  <= cnt_q - QB_W'(1);
					if (cnt_q == QB_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/yin_back.sv]
// ----------------------------------------------------------------------------
// yin_back
// Frame analysis: difference MAC pipeline, normalization, lag search,
// parabolic refinement and pitch division.
// ----------------------------------------------------------------------------
module yin_back #(
	parameter int FRAME_MAX = 2048,
	parameter int LAG_MAX   = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  yin_pkg::cfg_t        cfg,
	input  yin_pkg::frame_wr_t   wr,
	input  logic                 q_empty,
	input  yin_pkg::frame_desc_t head,
	output logic                 pop,
	output logic                 busy,
	output yin_pkg::result_t     result,
	output logic                 done
);
	import yin_pkg::*;

	localparam int FA   = $clog2(FRAME_MAX);
	localparam int FW   = $clog2(FRAME_MAX + 1);
	localparam int LA   = $clog2(LAG_MAX);
	localparam int LW   = $clog2(LAG_MAX + 1);
	localparam int SUMW = DIFF_W + LA;
	localparam int PW   = DIFF_W + LA;
	localparam int NDW  = PW + 16;
	localparam int SPW  = CFG_W + FW;
	localparam int EW   = (SPW > ENERGY_W) ? SPW : ENERGY_W;
	localparam int SQW  = 2 * (SAMPLE_BITS + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_DIFF, ST_DRAIN, ST_NRD, ST_NWAIT, ST_NMUL, ST_NDIV,
		ST_NUPD, ST_NEXT, ST_FIN, ST_IA, ST_IB, ST_IC, ST_ID, ST_IE, ST_IDIV,
		ST_LAG, ST_PITCH, ST_PDIV, ST_OUT
	} state_t;

	typedef enum logic [1:0] {SR_SEEK, SR_WALK, SR_DONE} srch_t;

	logic signed [SAMPLE_BITS-1:0] fmem [FRAME_MAX];
	logic [DIFF_W-1:0]             dmem [LAG_MAX];

	state_t              state_q;
	srch_t               mode_q;
	logic [FW-1:0]       n_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [LW-1:0]       tmax_q;
	logic [LA-1:0]       t_q, cand_q, gidx_q, tau_q;
	logic [FA-1:0]       j_q;
	logic [SUMW-1:0]     sum_q, sum_nx;
	logic [PW-1:0]       p_q;
	logic [NORM_W-1:0]   nv_q, cv_q, gmin_q;
	logic                gval_q, hit_q, neg_q;
	logic [DIFF_W-1:0]   a_q, b_q, c_q;
	logic [QUOT_W-1:0]   qmag_q;
	logic [17:0]         lag_q;
	result_t             res_q;
	logic                done_q;

	logic                div_start_q, div_done, div_sat;
	logic [NDW-1:0]      div_n_q;
	logic [SUMW-1:0]     div_d_q;
	logic [QB_W-1:0]     div_qb_q;
	logic [QUOT_W-1:0]   div_quot;

	logic                issue, last_iss;
	logic [FW-1:0]       jlast, jt;
	logic [FA-1:0]       ra0, ra1;
	logic                v_s1, v_s2, last_s1, last_s2;
	logic [LA-1:0]       t_s1, t_s2;
	logic signed [SAMPLE_BITS-1:0] f0_s1, f1_s1;
	logic signed [SAMPLE_BITS:0]   dl;
	logic signed [SQW-1:0] dsq;
	logic [SQW-1:0]      sq_s2;
	logic [DIFF_W-1:0]   acc_q, acc_nx;
	logic [DIFF_W:0]     acc_sum;
	logic                dwe;
	logic [LA-1:0]       dra;
	logic [DIFF_W-1:0]   drd;

	logic [EW-1:0]       sil_prod;
	logic                silent;
	logic [15:0]         tc;
	logic [LA-1:0]       tau_sel;
	logic signed [DIFF_W+2:0] den;
	logic signed [DIFF_W:0]   amc;
	logic signed [DIFF_W+7:0] num;
	logic [DIFF_W+7:0]   num_abs;
	logic [DIFF_W+2:0]   den_abs;
	logic signed [LAGS_W-1:0] lag_base, lag_s;

	// Difference pipeline
	assign issue    = state_q == ST_DIFF;
	assign jlast    = n_q - FW'(t_q) - FW'(1);
	assign last_iss = FW'(j_q) == jlast;
	assign jt       = FW'(j_q) + FW'(t_q);
	assign ra0      = j_q;
	assign ra1      = jt[FA-1:0];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			fmem[wr.addr[FA-1:0]] <= wr.data;
		end
		f0_s1 <= fmem[ra0];
		f1_s1 <= fmem[ra1];
	end

	assign dl      = (SAMPLE_BITS+1)'(f0_s1) - (SAMPLE_BITS+1)'(f1_s1);
	assign dsq     = dl * dl;
	assign acc_sum = (DIFF_W+1)'(acc_q) + (DIFF_W+1)'(sq_s2);
	assign acc_nx  = (acc_sum > (DIFF_W+1)'(DIFF_CAP)) ? DIFF_CAP : acc_sum[DIFF_W-1:0];
	assign dwe     = v_s2 && last_s2;

	always_ff @(posedge clk) begin
		last_s1 <= last_iss;
		t_s1    <= t_q;
		last_s2 <= last_s1;
		t_s2    <= t_s1;
		sq_s2   <= unsigned'(dsq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= last_s2 ? '0 : acc_nx;
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_IA:   dra = tau_q - LA'(1);
			ST_IB:   dra = tau_q;
			ST_IC:   dra = tau_q + LA'(1);
			default: dra = t_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dwe) begin
			dmem[t_s2] <= acc_nx;
		end
		drd <= dmem[dra];
	end

	// Frame checks and lag range
	assign sil_prod = EW'(cfg.silence_level) * EW'(n_q);
	assign silent   = EW'(energy_q) < sil_prod;

	always_comb begin
		tc = 16'(cfg.lag_max);
		if (16'(n_q >> 1) < tc) begin
			tc = 16'(n_q >> 1);
		end
		if (16'(LAG_MAX) < tc) begin
			tc = 16'(LAG_MAX);
		end
	end

	assign sum_nx  = (t_q == '0) ? '0 : sum_q + SUMW'(drd);
	assign tau_sel = (mode_q != SR_SEEK) ? cand_q : gidx_q;

	// Parabolic refinement
	assign amc      = $signed({1'b0, a_q}) - $signed({1'b0, c_q});
	assign num      = $signed({amc, 7'b0});
	assign den      = $signed({3'b0, a_q}) + $signed({3'b0, c_q}) - $signed({2'b0, b_q, 1'b0});
	assign num_abs  = num[DIFF_W+7] ? unsigned'(-num) : unsigned'(num);
	assign den_abs  = den[DIFF_W+2] ? unsigned'(-den) : unsigned'(den);
	assign lag_base = $signed(LAGS_W'({tau_q, 8'b0}));
	assign lag_s    = neg_q ? lag_base - $signed(LAGS_W'(qmag_q))
	                        : lag_base + $signed(LAGS_W'(qmag_q));

	yin_div #(
		.N_W (NDW),
		.D_W (SUMW),
		.Q_W (QUOT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_n_q),
		.divisor  (div_d_q),
		.qbits    (div_qb_q),
		.done     (div_done),
		.quot     (div_quot),
		.sat      (div_sat)
	);

	assign pop    = (state_q == ST_IDLE) && !q_empty;
	assign busy   = state_q != ST_IDLE;
	assign result = res_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= SR_SEEK;
			gval_q      <= 1'b0;
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						n_q      <= head.n[FW-1:0];
						energy_q <= head.energy;
						state_q  <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (silent) begin
						res_q   <= '{pitch_q4: '0, lag_q8: '0, silent: 1'b1,
						             below_threshold: 1'b0};
						state_q <= ST_OUT;
					end else if (16'(cfg.lag_min) >= tc) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						res_q   <= '0;
						tmax_q  <= LW'(tc);
						t_q     <= '0;
						j_q     <= '0;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					if (last_iss) begin
						j_q <= '0;
						if (16'(t_q) + 16'd1 == 16'(tmax_q)) begin
							state_q <= ST_DRAIN;
						end else begin
							t_q <= t_q + LA'(1);
						end
					end else begin
						j_q <= j_q + FA'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						t_q     <= '0;
						sum_q   <= '0;
						mode_q  <= SR_SEEK;
						gval_q  <= 1'b0;
						state_q <= ST_NRD;
					end
				end
				ST_NRD: state_q <= ST_NWAIT;
				ST_NWAIT: begin
					sum_q <= sum_nx;
					if (16'(t_q) < 16'(cfg.lag_min)) begin
						state_q <= ST_NEXT;
					end else if (t_q == '0 || sum_nx == '0) begin
						nv_q    <= NORM_ONE;
						state_q <= ST_NUPD;
					end else begin
						p_q     <= PW'(drd) * PW'(t_q);
						state_q <= ST_NMUL;
					end
				end
				ST_NMUL: begin
					div_start_q <= 1'b1;
					div_n_q     <= {p_q, 16'b0};
					div_d_q     <= sum_q;
					div_qb_q    <= QB_NORM;
					state_q     <= ST_NDIV;
				end
				ST_NDIV: begin
					if (div_done) begin
						nv_q    <= div_sat ? NORM_CAP : div_quot[NORM_W-1:0];
						state_q <= ST_NUPD;
					end
				end
				ST_NUPD: begin
					if (!gval_q || nv_q < gmin_q) begin
						gmin_q <= nv_q;
						gidx_q <= t_q;
						gval_q <= 1'b1;
					end
					case (mode_q)
						SR_SEEK: begin
							if (nv_q < NORM_W'(cfg.threshold_q16)) begin
								mode_q <= SR_WALK;
								cand_q <= t_q;
								cv_q   <= nv_q;
							end
						end
						SR_WALK: begin
							if (nv_q < cv_q) begin
								cand_q <= t_q;
								cv_q   <= nv_q;
							end else begin
								mode_q <= SR_DONE;
							end
						end
						default: mode_q <= mode_q;
					endcase
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (16'(t_q) + 16'd1 == 16'(tmax_q)) begin
						state_q <= ST_FIN;
					end else begin
						t_q     <= t_q + LA'(1);
						state_q <= ST_NRD;
					end
				end
				ST_FIN: begin
					tau_q  <= tau_sel;
					hit_q  <= mode_q != SR_SEEK;
					qmag_q <= '0;
					neg_q  <= 1'b0;
					if (tau_sel != '0 && 16'(tau_sel) + 16'd1 < 16'(tmax_q)) begin
						state_q <= ST_IA;
					end else begin
						state_q <= ST_LAG;
					end
				end
				ST_IA: state_q <= ST_IB;
				ST_IB: begin
					a_q     <= drd;
					state_q <= ST_IC;
				end
				ST_IC: begin
					b_q     <= drd;
					state_q <= ST_ID;
				end
				ST_ID: begin
					c_q     <= drd;
					state_q <= ST_IE;
				end
				ST_IE: begin
					if (den == '0) begin
						state_q <= ST_LAG;
					end else begin
						div_start_q <= 1'b1;
						div_n_q     <= NDW'(num_abs);
						div_d_q     <= SUMW'(den_abs);
						div_qb_q    <= QB_INTERP;
						neg_q       <= num[DIFF_W+7] ^ den[DIFF_W+2];
						state_q     <= ST_IDIV;
					end
				end
				ST_IDIV: begin
					if (div_done) begin
						qmag_q  <= div_sat ? '1 : div_quot;
						state_q <= ST_LAG;
					end
				end
				ST_LAG: begin
					if (lag_s < 0) begin
						lag_q <= '0;
					end else if (lag_s > $signed(LAGS_W'(262143))) begin
						lag_q <= '1;
					end else begin
						lag_q <= lag_s[17:0];
					end
					state_q <= ST_PITCH;
				end
				ST_PITCH: begin
					if (lag_q == '0) begin
						res_q.pitch_q4        <= '0;
						res_q.lag_q8          <= '0;
						res_q.silent          <= 1'b0;
						res_q.below_threshold <= hit_q;
						state_q               <= ST_OUT;
					end else begin
						div_start_q <= 1'b1;
						div_n_q     <= NDW'({cfg.sample_rate, 12'b0});
						div_d_q     <= SUMW'(lag_q);
						div_qb_q    <= QB_PITCH;
						state_q     <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (div_done) begin
						res_q.pitch_q4        <= div_sat ? 16'hFFFF : div_quot[15:0];
						res_q.lag_q8          <= lag_q;
						res_q.silent          <= 1'b0;
						res_q.below_threshold <= hit_q;
						state_q               <= ST_OUT;
					end
				end
				ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/yin_pitch_detector.sv]
// ----------------------------------------------------------------------------
// yin_pitch_detector
// Frame-based YIN pitch detector with a plain configuration write port.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low; the marked last sample
// closes the frame and raises busy. Analysis sums N-t squared differences for each lag t<T
// in the single difference MAC, then normalizes each lag from lag_min on in the shared
// divider (lower lags only feed the running sum), then refinement and pitch division.
// One result strobe per frame on done, one cycle wide; the receiver cannot stall.
// Reset clears counters and control and restores register defaults; stores need no clearing.
module yin_pitch_detector #(
	parameter int FRAME_MAX = 2048,
	parameter int LAG_MAX   = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  yin_pkg::item_t   item,
	output logic             done,
	output yin_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [29:0]      cfg_data
);
	import yin_pkg::*;

	cfg_t        cfg_q;
	frame_wr_t   fwr;
	frame_desc_t push_desc, head;
	logic        accept, push, pop, q_empty, back_busy;

	assign accept = start && !busy;
	assign busy   = !q_empty || back_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_RATE:   cfg_q.sample_rate   <= cfg_data[17:0];
				REG_FRAME_LENGTH:  cfg_q.frame_length  <= cfg_data[11:0];
				REG_THRESHOLD:     cfg_q.threshold_q16 <= cfg_data[15:0];
				REG_LAG_MIN:       cfg_q.lag_min       <= cfg_data[9:0];
				REG_LAG_MAX:       cfg_q.lag_max       <= cfg_data[10:0];
				REG_SILENCE_LEVEL: cfg_q.silence_level <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	yin_front #(
		.FRAME_MAX (FRAME_MAX)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.frame_length (cfg_q.frame_length),
		.wr           (fwr),
		.push         (push),
		.desc         (push_desc)
	);

	yin_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_desc),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty)
	);

	yin_back #(
		.FRAME_MAX (FRAME_MAX),
		.LAG_MAX   (LAG_MAX)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.wr      (fwr),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.busy    (back_busy),
		.result  (result),
		.done    (done)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while frame still in flight");

	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last_sample) |=> busy)
		else $error("frame close did not raise busy");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.silent) |->
		(result.pitch_q4 == 16'd0 && result.lag_q8 == 18'd0 && !result.below_threshold))
		else $error("silent transaction carries nonzero fields");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

[test/yin_pitch_detector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yin_pitch_detector_tb
// Self-checking bench for the frame-based YIN pitch detector.
// ----------------------------------------------------------------------------
// Frames of periodic, noisy, constant and full-scale samples are streamed in
// under several register settings and sender gap rates. A scoreboard predicts
// the pitch, lag, silence and threshold flags of each frame and checks every
// done strobe against the oldest prediction.
module yin_pitch_detector_tb;
	import yin_pkg::*;

	typedef enum int {FR_PERIODIC, FR_NOISE, FR_CONSTANT, FR_FULL_SCALE} frame_kind_e;

	class pitch_scoreboard;
		int unsigned rate, flen, thr, lmin, lmax, silence;
		int frame [2048];
		longint unsigned diff [1024];
		int unsigned nrm [1024];
		int unsigned count;
		longint unsigned energy;
		result_t pending [$];
		int errors, frames, samples, silent_frames, hits;

		function new();
			rate = 44100; flen = 2048; thr = 6554; lmin = 44; lmax = 882; silence = 0;
			count = 0; energy = 0; errors = 0; frames = 0; samples = 0;
			silent_frames = 0; hits = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [29:0] val);
			case (idx)
				REG_SAMPLE_RATE: rate = val[17:0];
				REG_FRAME_LENGTH: flen = val[11:0];
				REG_THRESHOLD: thr = val[15:0];
				REG_LAG_MIN: lmin = val[9:0];
				REG_LAG_MAX: lmax = val[10:0];
				REG_SILENCE_LEVEL: silence = val;
				default: ;
			endcase
		endfunction

		function int unsigned norm_of(longint unsigned d, int unsigned t, longint unsigned s);
			longint unsigned p, q, r;
			if (s == 0)
				return 65536;
			p = d * t;
			q = p / s;
			if (q >= 4)
				return 262143;
			r = p % s;
			for (int i = 0; i < 16; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= s) begin
					r -= s;
					q |= 1;
				end
			end
			return (q > 262143) ? 262143 : int'(q);
		endfunction

		function result_t pitch_of_frame();
			result_t r;
			int unsigned n, tmax, tau;
			longint unsigned s, acc, dd;
			longint a, b, c, den, lag, dl;
			bit found, hit;
			r = '0;
			n = count;
			found = 0;
			hit = 0;
			tau = 0;
			if (energy < longint'(silence) * n) begin
				r.silent = 1;
				silent_frames++;
				return r;
			end
			tmax = lmax;
			if (tmax > n / 2) tmax = n / 2;
			if (tmax > 1024) tmax = 1024;
			for (int unsigned t = 0; t < tmax; t++) begin
				acc = 0;
				for (int unsigned j = 0; j + t < n; j++) begin
					dl = frame[j] - frame[j + t];
					dd = dl * dl;
					acc += dd;
					if (acc > 64'h3FFF_FFFF_FFFF) acc = 64'h3FFF_FFFF_FFFF;
				end
				diff[t] = acc;
			end
			s = 0;
			for (int unsigned t = 0; t < tmax; t++) begin
				if (t == 0) begin
					nrm[0] = 65536;
				end else begin
					s += diff[t];
					nrm[t] = norm_of(diff[t], t, s);
				end
			end
			for (int unsigned t = lmin; t < tmax; t++) begin
				if (nrm[t] < thr) begin
					while (t + 1 < tmax && nrm[t + 1] < nrm[t])
						t++;
					tau = t;
					hit = 1;
					found = 1;
					break;
				end
			end
			if (!found && lmin < tmax) begin
				tau = lmin;
				for (int unsigned t = lmin + 1; t < tmax; t++)
					if (nrm[t] < nrm[tau])
						tau = t;
				found = 1;
			end
			if (!found)
				return r;
			lag = longint'(tau) * 256;
			if (tau > 0 && tau + 1 < tmax) begin
				a = diff[tau - 1];
				b = diff[tau];
				c = diff[tau + 1];
				den = a + c - 2 * b;
				if (den != 0)
					lag += ((a - c) * 128) / den;
			end
			if (lag < 0) lag = 0;
			if (lag > 262143) lag = 262143;
			if (lag > 0) begin
				a = (longint'(rate) * 4096) / lag;
				r.pitch_q4 = (a > 65535) ? 16'hFFFF : a[15:0];
			end
			r.lag_q8 = lag[17:0];
			r.below_threshold = hit;
			if (hit) hits++;
			return r;
		endfunction

		function void note_sample(item_t it);
			int unsigned cap;
			int v;
			cap = (flen < 1) ? 1 : ((flen > 2048) ? 2048 : flen);
			samples++;
			if (count < cap) begin
				v = it.sample;
				frame[count] = v;
				count++;
				energy += longint'(v) * longint'(v);
				if (energy > 64'h3FF_FFFF_FFFF) energy = 64'h3FF_FFFF_FFFF;
			end
			if (it.last_sample) begin
				pending.push_back(pitch_of_frame());
				frames++;
				count = 0;
				energy = 0;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result pitch=%0d lag=%0d silent=%0b below=%0b",
					$time, got.pitch_q4, got.lag_q8, got.silent, got.below_threshold);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.pitch_q4 !== exp_r.pitch_q4) begin
				$display("%0t: pitch_q4 expected %0d actual %0d", $time, exp_r.pitch_q4,
					got.pitch_q4);
				errors++;
			end
			if (got.lag_q8 !== exp_r.lag_q8) begin
				$display("%0t: lag_q8 expected %0d actual %0d", $time, exp_r.lag_q8, got.lag_q8);
				errors++;
			end
			if (got.silent !== exp_r.silent) begin
				$display("%0t: silent expected %0b actual %0b", $time, exp_r.silent, got.silent);
				errors++;
			end
			if (got.below_threshold !== exp_r.below_threshold) begin
				$display("%0t: below_threshold expected %0b actual %0b", $time,
					exp_r.below_threshold, got.below_threshold);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [29:0] cfg_data;

	pitch_scoreboard sb;
	int unsigned idle_pct;
	longint unsigned cycles;

	yin_pitch_detector u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	task automatic send_sample(logic signed [15:0] smp, logic last);
		item_t it;
		it.sample = smp;
		it.last_sample = last;
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		sb.note_sample(it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_frame(frame_kind_e kind, int unsigned len);
		int unsigned per, amp, nz, base;
		int v;
		per = $urandom_range(2, 20);
		amp = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(100, 30000);
		nz = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2000);
		base = $urandom;
		for (int unsigned j = 0; j < len; j++) begin
			case (kind)
				FR_PERIODIC: begin
					v = int'(amp) * (2 * int'(j % per) - int'(per)) / int'(per);
					if (nz != 0)
						v += int'($urandom_range(0, 2 * nz)) - int'(nz);
					if (v > 32767) v = 32767;
					if (v < -32768) v = -32768;
				end
				FR_NOISE: v = $signed(16'($urandom));
				FR_CONSTANT: v = $signed(base[15:0]);
				default: v = ($urandom_range(1) == 1) ? 32767 : -32768;
			endcase
			send_sample(v[15:0], j == len - 1);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [29:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_regs(int unsigned r, int unsigned fl, int unsigned th,
			int unsigned lmn, int unsigned lmx, int unsigned sl);
		write_reg(REG_SAMPLE_RATE, 30'(r));
		write_reg(REG_FRAME_LENGTH, 30'(fl));
		write_reg(REG_THRESHOLD, 30'(th));
		write_reg(REG_LAG_MIN, 30'(lmn));
		write_reg(REG_LAG_MAX, 30'(lmx));
		write_reg(REG_SILENCE_LEVEL, 30'(sl));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned phase, len, pick;
		frame_kind_e kind;
		sb = new();
		cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SAMPLE_RATE;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: short frames leave no lag to search
		send_sample(16'sd32767, 1'b1);
		send_frame(FR_PERIODIC, 6);
		drain();
		set_regs(192000, 64, 65535, 2, 1024, 0);
		send_frame(FR_FULL_SCALE, 8);
		send_frame(FR_CONSTANT, 6);
		send_frame(FR_PERIODIC, 10);
		drain();
		set_regs(8000, 64, 0, 1023, 3, 30'h3FFF_FFFF);
		send_frame(FR_NOISE, 4);
		drain();

		phase = 0;
		while (phase < 5) begin
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 75;
				2: idle_pct = 0;
				default: idle_pct = 21;
			endcase
			case (phase)
				0: set_regs(8000, 64, 0, 2, 3, 0);
				1: set_regs(192000, 2048, 65535, 2, 1024, 0);
				2: set_regs(44100, 64, 6554, 3, 1024, 2000000);
				default: set_regs($urandom_range(8000, 192000), $urandom_range(64, 2048),
					$urandom_range(0, 65535), $urandom_range(2, 12), $urandom_range(3, 1024),
					$urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 3000000));
			endcase
			for (int k = 0; k < 120; k++) begin
				pick = $urandom_range(99);
				kind = pick < 70 ? FR_PERIODIC : pick < 85 ? FR_NOISE :
					pick < 93 ? FR_CONSTANT : FR_FULL_SCALE;
				len = $urandom_range(0, 15) == 0 ? $urandom_range(60, 80) : $urandom_range(2, 40);
				send_frame(kind, len);
				k += len;
				if ($urandom_range(0, 9) == 0) begin
					start <= 1'b0;
					while (sb.pending.size() != 0)
						@(posedge clk);
				end
			end
			drain();
			phase++;
		end

		$display("Checked %0d frames from %0d samples over %0d register settings.",
			sb.frames, sb.samples, phase + 3);
		$display("Silent frames: %0d, threshold hits: %0d.", sb.silent_frames, sb.hits);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
